// File: design/fbsn_pkg.sv
// fbsn_pkg: shared types and constants for the background subtract / normalize unit
// used by fbsn_ctrl, fbsn_dp and the top level
`timescale 1ns / 1ps
package fbsn_pkg;

  localparam int unsigned SUM_W  = 24;
  localparam int unsigned DIFF_W = 25;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned PROD_W = PIX_W + DIFF_W;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [1:0] CMD_BACKGROUND = 2'd0;
  localparam logic [1:0] CMD_FRAME      = 2'd1;
  localparam logic [1:0] CMD_EMIT       = 2'd2;

  localparam logic CFG_AVG_FRAMES  = 1'b0;
  localparam logic CFG_PIXEL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } fbsn_state_t;

  typedef struct packed {
    logic       rd;      // launch memory read
    logic       exec;    // apply command using read data
    logic       div_go;  // start the divider
    logic       out_set; // present result word
  } fbsn_cmd_t;

  typedef struct packed {
    logic emit_ok;  // frame complete: emit will produce a word
    logic div_busy;
    logic div_trivial; // emit result known without division
  } fbsn_sts_t;

endpackage

// File: design/fbsn_ctrl.sv
// fbsn_ctrl: per-word sequencer for the background subtract / normalize unit
// depends on fbsn_pkg
`timescale 1ns / 1ps
module fbsn_ctrl
  import fbsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic        out_busy,
  input  fbsn_sts_t   sts,
  output fbsn_cmd_t   ctl
);

  fbsn_state_t state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmd_r   <= CMD_BACKGROUND;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    ctl       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.rd    = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd_r == CMD_EMIT) begin
          if (!sts.emit_ok) begin
            state_nxt = ST_IDLE;
          end else if (sts.div_trivial) begin
            state_nxt = ST_OUT;
          end else begin
            ctl.div_go = 1'b1;
            state_nxt  = ST_DIV;
          end
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (!sts.div_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          ctl.out_set = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_set |-> $past(state_r) == ST_DIV || $past(state_r) == ST_READ
                   || $past(state_r) == ST_OUT)
    else $error("result word without emit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_go |=> state_r == ST_DIV)
    else $error("divider start lost");

endmodule

// File: design/fbsn_dp.sv
// fbsn_dp: memories, running bounds, restoring divider and output register
// depends on fbsn_pkg; sequenced by fbsn_ctrl
`timescale 1ns / 1ps
module fbsn_dp
  import fbsn_pkg::*;
#(
  parameter int unsigned MAX_PIXELS     = 524288,
  parameter int unsigned MAX_AVG_FRAMES = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [19:0]       cfg_data,
  input  logic              in_accept,
  input  logic [1:0]        cmd,
  input  logic [PIX_W-1:0]  pixel_value,
  input  fbsn_cmd_t         ctl,
  output fbsn_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_pixel,
  output logic              last_of_frame
);

  localparam int unsigned AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CNT_W = (MAX_PIXELS > 1048575) ? CW : 20;
  localparam int unsigned DCNT_W = $clog2(PROD_W + 1);

  // config registers
  logic [7:0]  avg_r;
  logic [19:0] cnt_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r     <= 8'd1;
      cnt_cfg_r <= 20'd524288 > 20'hFFFFF ? 20'hFFFFF : 20'(524288);
    end else if (cfg_we) begin
      if (cfg_index == CFG_AVG_FRAMES) avg_r <= cfg_data[7:0];
      else                             avg_r <= avg_r;
      if (cfg_index == CFG_PIXEL_COUNT) cnt_cfg_r <= cfg_data;
    end
  end

  // effective values
  logic [CNT_W-1:0] cnt_ext;
  logic [CW-1:0]    eff_cnt;
  logic [7:0]       eff_avg;
  always_comb begin
    cnt_ext = CNT_W'(cnt_cfg_r);
    if (cnt_ext == '0) eff_cnt = CW'(1);
    else if (cnt_ext > CNT_W'(MAX_PIXELS)) eff_cnt = CW'(MAX_PIXELS);
    else eff_cnt = CW'(cnt_ext);
    eff_avg = (avg_r == 8'd0) ? 8'd1 : avg_r;
    if (32'(eff_avg) > MAX_AVG_FRAMES) eff_avg = 8'(MAX_AVG_FRAMES);
  end

  // command word latch
  logic [1:0]       cmd_r;
  logic [PIX_W-1:0] x_r;
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= cmd;
      x_r   <= pixel_value;
    end
  end

  // state
  logic [CW-1:0]          load_pos_r, emit_pos_r;
  logic [7:0]             bg_seen_r;
  logic [PIX_W-1:0]       peak_r;
  logic signed [DIFF_W-1:0] dlo_r, dhi_r;
  logic                   complete_r;

  logic [AW-1:0] lpos, epos;
  assign lpos = (load_pos_r >= CW'(MAX_PIXELS)) ? '0 : load_pos_r[AW-1:0];
  assign epos = (emit_pos_r >= CW'(MAX_PIXELS)) ? '0 : emit_pos_r[AW-1:0];

  // memories
  logic [SUM_W-1:0]  bg_mem [MAX_PIXELS];
  logic [DIFF_W-1:0] df_mem [MAX_PIXELS];
  logic [SUM_W-1:0]  bg_rd_r;
  logic [DIFF_W-1:0] df_rd_r;
  logic              bg_we, df_we;
  logic [SUM_W-1:0]  bg_wd;
  logic signed [DIFF_W-1:0] d_val;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      bg_rd_r <= bg_mem[lpos];
      df_rd_r <= df_mem[epos];
    end
    if (bg_we) bg_mem[lpos] <= bg_wd;
  end
  always_ff @(posedge clk) begin
    if (df_we) df_mem[lpos] <= d_val;
  end

  // exec datapath
  logic [SUM_W:0] bg_add;
  logic [23:0]    nx;
  logic           bg_ok, wrap;
  assign bg_add = {1'b0, bg_rd_r} + (SUM_W+1)'(x_r);
  assign nx     = 24'(eff_avg) * 24'(x_r);
  assign d_val  = $signed({1'b0, nx}) - $signed({1'b0, bg_rd_r});
  assign bg_ok  = bg_seen_r < eff_avg;
  assign wrap   = (CW+1)'(lpos) + (CW+1)'(1) >= (CW+1)'(eff_cnt);
  assign bg_we  = ctl.exec && cmd_r == CMD_BACKGROUND && bg_ok;
  assign df_we  = ctl.exec && cmd_r == CMD_FRAME;
  always_comb begin
    if (bg_seen_r == 8'd0) bg_wd = SUM_W'(x_r);
    else if (bg_add[SUM_W]) bg_wd = SUM_MAX;
    else bg_wd = bg_add[SUM_W-1:0];
  end

  // divider: quotient = peak*off/span, one bit a cycle
  logic [PROD_W-1:0]  prod_r;
  logic [DIFF_W:0]    span, off_raw, off;
  logic [DIFF_W:0]    span_r, rem_r;
  logic [PROD_W-1:0]  quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               dbusy_r;
  logic [DIFF_W+1:0]  rem_sh;
  logic               emit_last;

  assign span    = $signed({dhi_r[DIFF_W-1], dhi_r}) - $signed({dlo_r[DIFF_W-1], dlo_r});
  assign off_raw = $signed({df_rd_r[DIFF_W-1], df_rd_r}) - $signed({dlo_r[DIFF_W-1], dlo_r});
  always_comb begin
    if (off_raw[DIFF_W]) off = '0;
    else if (off_raw > span) off = span;
    else off = off_raw;
  end
  assign rem_sh    = {rem_r, prod_r[PROD_W-1]};
  assign emit_last = (CW+1)'(epos) + (CW+1)'(1) >= (CW+1)'(eff_cnt);

  assign sts.emit_ok     = complete_r;
  assign sts.div_busy    = dbusy_r;
  assign sts.div_trivial = (span == '0) || span[DIFF_W];

  // product loaded into prod_r together with ctl.div_go, which starts the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (ctl.div_go) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= DCNT_W'(PROD_W);
      prod_r  <= PROD_W'(peak_r) * PROD_W'(off[DIFF_W-1:0]);
      span_r  <= span;
      rem_r   <= '0;
      quo_r   <= '0;
    end else if (dbusy_r) begin
      prod_r <= {prod_r[PROD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, span_r}) begin
        rem_r <= (DIFF_W+1)'(rem_sh - {1'b0, span_r});
        quo_r <= {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIFF_W:0];
        quo_r <= {quo_r[PROD_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - DCNT_W'(1);
      if (dcnt_r == DCNT_W'(1)) dbusy_r <= 1'b0;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      bg_seen_r  <= '0;
      peak_r     <= '0;
      dlo_r      <= '0;
      dhi_r      <= '0;
      emit_pos_r <= '0;
      complete_r <= 1'b0;
    end else begin
      if (bg_we) begin
        load_pos_r <= wrap ? '0 : CW'(lpos) + CW'(1);
        if (wrap && bg_seen_r != 8'd255) bg_seen_r <= bg_seen_r + 8'd1;
      end
      if (df_we) begin
        load_pos_r <= wrap ? '0 : CW'(lpos) + CW'(1);
        if (lpos == '0) begin
          peak_r     <= x_r;
          dlo_r      <= d_val;
          dhi_r      <= d_val;
          emit_pos_r <= '0;
          complete_r <= wrap;
        end else begin
          if (x_r > peak_r) peak_r <= x_r;
          if (d_val < dlo_r) dlo_r <= d_val;
          if (d_val > dhi_r) dhi_r <= d_val;
          if (wrap) complete_r <= 1'b1;
        end
      end
      if (ctl.out_set) begin
        if (emit_last) begin
          emit_pos_r <= '0;
          complete_r <= 1'b0;
        end else begin
          emit_pos_r <= CW'(epos) + CW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.out_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.out_set) begin
      out_pixel     <= sts.div_trivial ? '0 : quo_r[PIX_W-1:0];
      last_of_frame <= emit_last;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> dlo_r <= dhi_r)
    else $error("difference bounds crossed");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_set |-> !dbusy_r)
    else $error("result taken during divide");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled word dropped");

endmodule

// File: design/fixed_background_subtract_normalize_unit.sv
// fixed_background_subtract_normalize_unit: top level, controller plus datapath
// sequence: background/frame word runs idle, read, exec; emit word runs idle, read,
//   divide, out, skipping divide when the difference span is flat; output stalls hold out
// input: a new word is accepted only once the previous one has finished; an emit
//   runs the 41-step restoring divider (one quotient bit a cycle) between read and out
// reset: synchronous active-low rst_n clears control state; pixel memories
//   are not cleared and hold undefined data until written
`timescale 1ns / 1ps
module fixed_background_subtract_normalize_unit
  import fbsn_pkg::*;
#(
  parameter int unsigned MAX_PIXELS     = 524288,
  parameter int unsigned MAX_AVG_FRAMES = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [19:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [PIX_W-1:0]  in_pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_pixel,
  output logic              out_last_of_frame
);

  // controller/datapath handshake
  fbsn_cmd_t ctl;
  fbsn_sts_t sts;
  logic      in_accept;

  assign in_accept = in_valid && !in_stall;

  // the output register may still hold a word: wait for it to drain
  fbsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (in_cmd),
    .out_busy (out_valid && out_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  fbsn_dp #(
    .MAX_PIXELS     (MAX_PIXELS),
    .MAX_AVG_FRAMES (MAX_AVG_FRAMES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .cmd           (in_cmd),
    .pixel_value   (in_pixel_value),
    .ctl           (ctl),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .last_of_frame (out_last_of_frame)
  );

endmodule
